[rtl/core/csq_pkg.sv]
// Shared codes, field widths and default sizes for the counting semaphore unit.
`default_nettype none

package csq_pkg;

  localparam int NUM_SEMS_DEF   = 16;
  localparam int WAIT_DEPTH_DEF = 16;

  localparam int OP_W     = 2;
  localparam int SID_W    = 4;
  localparam int PID_W    = 5;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOCK   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SUSPENDED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SEM     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

`default_nettype wire

[rtl/core/counting_semaphore_wait_queue_core.sv]
// Top level of the counting semaphore unit with per-semaphore FIFO wait queues.
//
//   channel | direction | beat carries                                  | handshake
//   in_     | input     | op, sem_id, caller_pid, initial_count         | in_valid/in_ready
//   out_    | output    | status, new_sem_id, woken_valid, woken_pid    | out_valid/out_ready
//
// A beat reads the semaphore state memory, then modifies it and writes it back.
// An unlock that releases a waiter then reads the wait store in a dequeue step.
// The next beat is taken in the write-back cycle; the state memory forwards that write.
// A waiting result leaves the input free; a full result register stalls write-back, or a release's dequeue.
// Synchronous reset clears control state and the written flags; no clearing pass.
`default_nettype none

module counting_semaphore_wait_queue_core
  import csq_pkg::*;
#(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [SID_W-1:0]    in_sem_id,
  input  wire logic [PID_W-1:0]    in_caller_pid,
  input  wire logic [COUNT_W-1:0]  in_initial_count,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SID_W-1:0]         out_new_sem_id,
  output logic                     out_woken_valid,
  output logic [PID_W-1:0]         out_woken_pid
);

  localparam int SW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int NFW  = $clog2(NUM_SEMS + 1);
  localparam int HW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FW   = $clog2(WAIT_DEPTH + 1);
  localparam int DW   = COUNT_W + HW + FW;
  localparam int SXW  = (SW > SID_W) ? SW : SID_W;
  localparam int NXW  = (NFW > SID_W) ? NFW : SID_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DEQ  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [SW-1:0]       sid_r;
  logic                sid_ok_r;
  logic [PID_W-1:0]    pid_r;
  logic [COUNT_W-1:0]  init_r;
  logic [NFW-1:0]      nfs_r, nfs_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SID_W-1:0]    out_new_sem_id_r;
  logic                out_woken_valid_r;
  logic [PID_W-1:0]    out_woken_pid_r;

  logic                in_fire;
  logic                out_free;
  logic [SXW-1:0]      sid_x;
  logic [SW-1:0]       in_idx;
  logic                in_sid_ok;
  logic [NXW-1:0]      nid_x;

  logic [DW-1:0]       st_rd_data;
  logic [COUNT_W-1:0]  cnt;
  logic [HW-1:0]       head;
  logic [FW-1:0]       fill;
  logic [FW:0]         slot_sum;
  logic [FW:0]         slot_adj;
  logic [HW:0]         head_inc;
  logic [HW-1:0]       head_next;
  logic                pool_ok;

  logic                deq;
  logic                go;
  logic                st_wr_req;
  logic [SW-1:0]       st_wr_addr;
  logic [DW-1:0]       st_wr_data;
  logic                wq_wr_req;
  logic [STATUS_W-1:0] res_status;
  logic [SID_W-1:0]    res_new_id;
  logic                nfs_adv;
  logic [PID_W-1:0]    wq_rd_data;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_EXEC) && !deq && out_free);
  assign in_fire  = in_valid && in_ready;

  assign sid_x     = SXW'(in_sem_id);
  assign in_idx    = sid_x[SW-1:0];
  assign in_sid_ok = {1'b0, sid_x} < (SXW+1)'(NUM_SEMS);
  assign nid_x     = NXW'(nfs_r);
  assign pool_ok   = nfs_r < NFW'(NUM_SEMS);

  assign cnt  = st_rd_data[DW-1 -: COUNT_W];
  assign head = st_rd_data[FW +: HW];
  assign fill = st_rd_data[FW-1:0];

  assign slot_sum  = (FW+1)'(head) + (FW+1)'(fill);
  assign slot_adj  = (slot_sum >= (FW+1)'(WAIT_DEPTH)) ? slot_sum - (FW+1)'(WAIT_DEPTH) : slot_sum;
  assign head_inc  = (HW+1)'(head) + (HW+1)'(1);
  assign head_next = (head_inc == (HW+1)'(WAIT_DEPTH)) ? '0 : head_inc[HW-1:0];

  always_comb begin
    deq        = 1'b0;
    st_wr_req  = 1'b0;
    st_wr_addr = sid_r;
    st_wr_data = st_rd_data;
    wq_wr_req  = 1'b0;
    res_status = ST_DONE;
    res_new_id = '0;
    nfs_adv    = 1'b0;
    unique case (op_r)
      OP_CREATE: begin
        if (pool_ok) begin
          st_wr_req  = 1'b1;
          st_wr_addr = nfs_r[SW-1:0];
          st_wr_data = {init_r, {HW{1'b0}}, {FW{1'b0}}};
          res_new_id = nid_x[SID_W-1:0];
          nfs_adv    = 1'b1;
        end else begin
          res_status = ST_NO_SEM;
        end
      end
      OP_LOCK: begin
        if (sid_ok_r) begin
          priority if (cnt != '0) begin
            st_wr_req  = 1'b1;
            st_wr_data = {cnt - COUNT_W'(1), head, fill};
          end else if (fill == FW'(WAIT_DEPTH)) begin
            res_status = ST_QUEUE_FULL;
          end else begin
            st_wr_req  = 1'b1;
            st_wr_data = {cnt, head, fill + FW'(1)};
            wq_wr_req  = 1'b1;
            res_status = ST_SUSPENDED;
          end
        end
      end
      OP_UNLOCK: begin
        if (sid_ok_r) begin
          if (fill == '0) begin
            if (cnt != COUNT_MAX) begin
              st_wr_req  = 1'b1;
              st_wr_data = {cnt + COUNT_W'(1), head, fill};
            end
          end else begin
            deq        = 1'b1;
            st_wr_req  = 1'b1;
            st_wr_data = {cnt, head_next, fill - FW'(1)};
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign go = (state_r == S_EXEC) && (deq || out_free);

  csq_state_ram #(
    .DEPTH (NUM_SEMS),
    .AW    (SW),
    .DW    (DW)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (go && st_wr_req),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (st_rd_data)
  );

  csq_wait_ram #(
    .ROWS (NUM_SEMS),
    .COLS (WAIT_DEPTH),
    .RAW  (SW),
    .CAW  (HW),
    .DW   (PID_W)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (go && wq_wr_req),
    .wr_row  (sid_r),
    .wr_col  (slot_adj[HW-1:0]),
    .wr_data (pid_r),
    .rd_en   (go && deq),
    .rd_row  (sid_r),
    .rd_col  (head),
    .rd_data (wq_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    nfs_nxt   = nfs_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          if (nfs_adv) begin
            nfs_nxt = nfs_r + NFW'(1);
          end
          priority if (deq) begin
            state_nxt = S_DEQ;
          end else if (in_fire) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DEQ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nfs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nfs_r   <= nfs_nxt;
      if ((go && !deq) || ((state_r == S_DEQ) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_op;
      sid_r    <= in_idx;
      sid_ok_r <= in_sid_ok;
      pid_r    <= in_caller_pid;
      init_r   <= in_initial_count;
    end
    if (go && !deq) begin
      out_status_r      <= res_status;
      out_new_sem_id_r  <= res_new_id;
      out_woken_valid_r <= 1'b0;
      out_woken_pid_r   <= '0;
    end else if ((state_r == S_DEQ) && out_free) begin
      out_status_r      <= ST_DONE;
      out_new_sem_id_r  <= '0;
      out_woken_valid_r <= 1'b1;
      out_woken_pid_r   <= wq_rd_data;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_new_sem_id  = out_new_sem_id_r;
  assign out_woken_valid = out_woken_valid_r;
  assign out_woken_pid   = out_woken_pid_r;

  a_nfs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfs_r <= NFW'(NUM_SEMS))
    else $error("allocation pointer beyond pool");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted beat not in write-back");

  a_deq_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ) && !$past(state_r == S_DEQ) |-> $past(state_r == S_EXEC && deq))
    else $error("dequeue entered without release");

  a_woken_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_woken_valid_r |-> (out_status_r == ST_DONE) && (out_new_sem_id_r == '0))
    else $error("release result carries other fields");

  a_no_accept_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ) |-> !in_ready)
    else $error("beat taken during dequeue");

endmodule

`default_nettype wire

[rtl/core/csq_state_ram.sv]
// Per-semaphore state memory (count, head, fill) with written flags and write-first read.
`default_nettype none

module csq_state_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [DW-1:0]    data_r;
  logic             data_vld_r;
  logic             fwd;

  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= fwd ? wr_data : mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      data_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        data_vld_r <= fwd | written_r[rd_addr];
      end
    end
  end

  // unwritten entries read as the cleared state
  assign rd_data = data_vld_r ? data_r : '0;

endmodule

`default_nettype wire

[rtl/core/csq_wait_ram.sv]
// Wait queue store: one row of process ids per semaphore, registered read.
`default_nettype none

module csq_wait_ram #(
  parameter int ROWS = 16,
  parameter int COLS = 16,
  parameter int RAW  = 4,
  parameter int CAW  = 4,
  parameter int DW   = 5
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [RAW-1:0] wr_row,
  input  wire logic [CAW-1:0] wr_col,
  input  wire logic [DW-1:0]  wr_data,
  input  wire logic           rd_en,
  input  wire logic [RAW-1:0] rd_row,
  input  wire logic [CAW-1:0] rd_col,
  output logic      [DW-1:0]  rd_data
);

  logic [DW-1:0] mem_r [ROWS][COLS];
  logic [DW-1:0] data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row][wr_col] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem_r[rd_row][rd_col];
    end
  end

  assign rd_data = data_r;

endmodule

`default_nettype wire
